[hdl/tgs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the trilinear grid sampler
// Field widths, operation and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package tgs_pkg;

	// default store dimensions
	localparam int unsigned MAX_X_DEF = 64;
	localparam int unsigned MAX_Y_DEF = 64;
	localparam int unsigned MAX_Z_DEF = 64;

	// field widths
	localparam int DATA_W    = 16;  // velocity component, signed Q11.4
	localparam int POS_W     = 16;  // position, signed, 8 fraction bits
	localparam int FRAC_W    = 8;
	localparam int BASE_W    = POS_W - FRAC_W;
	localparam int CELL_W    = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int LIM_W     = 9;   // clamp limit, up to 126
	localparam int CRD_W     = 10;  // signed corner coordinate before clamp
	localparam int WXY_W     = 17;  // product of two axis weights
	localparam int W_W       = 25;  // product of three axis weights, up to 2^24
	localparam int ACC_W     = 41;  // exact weighted sum
	localparam int ACC_SHIFT = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = 2'd2;
	localparam logic [CFG_W-1:0]     GRID_SIZE_RST   = 7'd64;

	// operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// corner sequencing
	localparam logic [2:0] LAST_CORNER = 3'd7;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

endpackage
`default_nettype wire

[hdl/trilinear_grid_sampler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_top: clamp-to-edge trilinear sampler over a 3D grid
// Holds a grid of velocity vectors in one single-port memory; write items
// store a cell, sample items blend the eight clamped corners of a position.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole grid memory to zero, one cell a
// cycle, over all MAX_X*MAX_Y*MAX_Z cells (262144 at the defaults); no
// item is taken during that sweep, configuration writes are. A write item
// is stored while the block stays idle. A sample item reads its eight
// corners one after another through the single memory port, lets the
// weight and multiply-accumulate pipeline drain, loads the result register,
// and the next item is taken once the sequencer is back in idle; out_valid
// rises together with the new result. The result register lets the next
// item in while the previous result waits to be taken; a sample that
// finishes while a result still waits holds in its last cycle until that
// result is taken.
module trilinear_grid_sampler_top
	import tgs_pkg::*;
#(
	parameter int unsigned MAX_X = MAX_X_DEF,
	parameter int unsigned MAX_Y = MAX_Y_DEF,
	parameter int unsigned MAX_Z = MAX_Z_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration
	input  wire                        cfg_we,
	input  wire  [CFG_IDX_W-1:0]       cfg_index,
	input  wire  [CFG_W-1:0]           cfg_data,
	// input items
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        op,
	input  wire  [CELL_W-1:0]          cell_x,
	input  wire  [CELL_W-1:0]          cell_y,
	input  wire  [CELL_W-1:0]          cell_z,
	input  wire  signed [DATA_W-1:0]   write_vx,
	input  wire  signed [DATA_W-1:0]   write_vy,
	input  wire  signed [DATA_W-1:0]   write_vz,
	input  wire  signed [POS_W-1:0]    pos_x,
	input  wire  signed [POS_W-1:0]    pos_y,
	input  wire  signed [POS_W-1:0]    pos_z,
	// result items
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [DATA_W-1:0]   sampled_vx,
	output logic signed [DATA_W-1:0]   sampled_vy,
	output logic signed [DATA_W-1:0]   sampled_vz
);

	localparam int CW_X  = $clog2(MAX_X);
	localparam int CW_Y  = $clog2(MAX_Y);
	localparam int CW_Z  = $clog2(MAX_Z);
	localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = $clog2(CELLS);
	localparam int MW    = 3 * DATA_W;

	// effective clamp limit (size - 1) from a size register
	function automatic logic [LIM_W-1:0] lim_of(input logic [CFG_W-1:0] r,
		input int unsigned m);
		logic [LIM_W-1:0] rv;
		rv = {2'b00, r};
		if (r == '0) begin
			lim_of = '0;
		end else if (rv > LIM_W'(m)) begin
			lim_of = LIM_W'(m - 1);
		end else begin
			lim_of = rv - 9'd1;
		end
	endfunction

	// clamp a signed corner coordinate to [0, lim]
	function automatic logic [LIM_W-1:0] clamp_of(input logic signed [CRD_W-1:0] c,
		input logic [LIM_W-1:0] lim);
		if (c[CRD_W-1]) begin
			clamp_of = '0;
		end else if (c > $signed({1'b0, lim})) begin
			clamp_of = lim;
		end else begin
			clamp_of = c[LIM_W-1:0];
		end
	endfunction

	// axis weight: f for the upper corner, 256 - f for the lower
	function automatic logic [LIM_W-1:0] wt_of(input logic hi,
		input logic [FRAC_W-1:0] f);
		if (hi) begin
			wt_of = {1'b0, f};
		end else begin
			wt_of = 9'd256 - {1'b0, f};
		end
	endfunction

	state_t                    state_q, state_d;
	logic [AW-1:0]             clear_addr_q;
	logic [2:0]                corner_q;
	logic                      v_s1, v_s2, v_s3;
	logic                      out_valid_q;
	logic [CFG_W-1:0]          grid_width_q, grid_height_q, grid_depth_q;

	logic signed [BASE_W-1:0]  base_x_q, base_y_q, base_z_q;
	logic [FRAC_W-1:0]         frac_x_q, frac_y_q, frac_z_q;
	logic [LIM_W-1:0]          lim_x_q, lim_y_q, lim_z_q;

	logic                      in_accept, sample_accept, load_out, issue, pipe_busy;
	logic                      mem_we, wr_in_range;
	logic [AW-1:0]             mem_addr, wr_addr, rd_addr;
	logic [MW-1:0]             mem_wdata;
	logic [MW-1:0]             velocity_mem_q [CELLS];

	logic signed [CRD_W-1:0]   crd_x, crd_y, crd_z;
	logic [CW_X-1:0]           cx;
	logic [CW_Y-1:0]           cy;
	logic [CW_Z-1:0]           cz;
	logic [LIM_W-1:0]          wx, wy, wz;
	logic [2*LIM_W-1:0]        wxy_full;
	logic [WXY_W+LIM_W-1:0]    w_full;

	logic [WXY_W-1:0]          wxy_s1;
	logic [LIM_W-1:0]          wz_s1;
	logic [MW-1:0]             rd_data_s1;
	logic [W_W-1:0]            w_s2;
	logic [MW-1:0]             vel_s2;
	logic signed [ACC_W:0]     prod_x, prod_y, prod_z;
	logic signed [ACC_W-1:0]   prod_x_s3, prod_y_s3, prod_z_s3;
	logic signed [ACC_W-1:0]   acc_x_q, acc_y_q, acc_z_q;
	logic signed [DATA_W-1:0]  res_x_q, res_y_q, res_z_q;

	assign in_accept     = in_valid && !in_stall;
	assign sample_accept = in_accept && (op == OP_SAMPLE);
	assign pipe_busy     = v_s1 || v_s2 || v_s3;

	// write address and range check
	assign wr_in_range = ({3'b000, cell_x} < LIM_W'(MAX_X))
		&& ({3'b000, cell_y} < LIM_W'(MAX_Y))
		&& ({3'b000, cell_z} < LIM_W'(MAX_Z));
	assign wr_addr = AW'(cell_x) + AW'(cell_y) * AW'(MAX_X)
		+ AW'(cell_z) * AW'(MAX_X * MAX_Y);

	// corner coordinates, clamped to the configured size
	assign crd_x = {{2{base_x_q[BASE_W-1]}}, base_x_q} + {9'd0, corner_q[0]};
	assign crd_y = {{2{base_y_q[BASE_W-1]}}, base_y_q} + {9'd0, corner_q[1]};
	assign crd_z = {{2{base_z_q[BASE_W-1]}}, base_z_q} + {9'd0, corner_q[2]};
	assign cx = CW_X'(clamp_of(crd_x, lim_x_q));
	assign cy = CW_Y'(clamp_of(crd_y, lim_y_q));
	assign cz = CW_Z'(clamp_of(crd_z, lim_z_q));
	assign rd_addr = AW'(cx) + AW'(cy) * AW'(MAX_X) + AW'(cz) * AW'(MAX_X * MAX_Y);

	// corner weights
	assign wx       = wt_of(corner_q[0], frac_x_q);
	assign wy       = wt_of(corner_q[1], frac_y_q);
	assign wz       = wt_of(corner_q[2], frac_z_q);
	assign wxy_full = wx * wy;
	assign w_full   = wxy_s1 * wz_s1;

	// component products
	assign prod_x = $signed(vel_s2[DATA_W-1:0]) * $signed({1'b0, w_s2});
	assign prod_y = $signed(vel_s2[2*DATA_W-1:DATA_W]) * $signed({1'b0, w_s2});
	assign prod_z = $signed(vel_s2[3*DATA_W-1:2*DATA_W]) * $signed({1'b0, w_s2});

	// sequencer next state and memory port control
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_addr  = clear_addr_q;
		mem_wdata = '0;
		issue     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clear_addr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_addr  = wr_addr;
				mem_wdata = {write_vz, write_vy, write_vx};
				if (in_valid) begin
					if (op == OP_SAMPLE) begin
						state_d = ST_ISSUE;
					end else begin
						mem_we = wr_in_range;
					end
				end
			end
			ST_ISSUE: begin
				mem_addr = rd_addr;
				issue    = 1'b1;
				if (corner_q == LAST_CORNER) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy && (!out_valid_q || !out_stall)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clear_addr_q  <= '0;
			corner_q      <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			out_valid_q   <= 1'b0;
			grid_width_q  <= GRID_SIZE_RST;
			grid_height_q <= GRID_SIZE_RST;
			grid_depth_q  <= GRID_SIZE_RST;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clear_addr_q <= clear_addr_q + 1'b1;
			end
			if (sample_accept) begin
				corner_q <= '0;
			end else if (issue) begin
				corner_q <= corner_q + 3'd1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					REG_GRID_DEPTH:  grid_depth_q  <= cfg_data;
					default:         ;
				endcase
			end
		end
	end

	// grid memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			velocity_mem_q[mem_addr] <= mem_wdata;
		end
		rd_data_s1 <= velocity_mem_q[mem_addr];
	end

	// sample setup: floor, fraction and clamp limits
	always_ff @(posedge clk) begin
		if (sample_accept) begin
			base_x_q <= pos_x[POS_W-1:FRAC_W];
			base_y_q <= pos_y[POS_W-1:FRAC_W];
			base_z_q <= pos_z[POS_W-1:FRAC_W];
			frac_x_q <= pos_x[FRAC_W-1:0];
			frac_y_q <= pos_y[FRAC_W-1:0];
			frac_z_q <= pos_z[FRAC_W-1:0];
			lim_x_q  <= lim_of(grid_width_q, MAX_X);
			lim_y_q  <= lim_of(grid_height_q, MAX_Y);
			lim_z_q  <= lim_of(grid_depth_q, MAX_Z);
		end
	end

	// weight and multiply-accumulate pipeline
	always_ff @(posedge clk) begin
		wxy_s1    <= wxy_full[WXY_W-1:0];
		wz_s1     <= wz;
		w_s2      <= w_full[W_W-1:0];
		vel_s2    <= rd_data_s1;
		prod_x_s3 <= prod_x[ACC_W-1:0];
		prod_y_s3 <= prod_y[ACC_W-1:0];
		prod_z_s3 <= prod_z[ACC_W-1:0];
		if (sample_accept) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else if (v_s3) begin
			acc_x_q <= acc_x_q + prod_x_s3;
			acc_y_q <= acc_y_q + prod_y_s3;
			acc_z_q <= acc_z_q + prod_z_s3;
		end
		// floor of the sum over 2^24
		if (load_out) begin
			res_x_q <= acc_x_q[ACC_SHIFT+DATA_W-1:ACC_SHIFT];
			res_y_q <= acc_y_q[ACC_SHIFT+DATA_W-1:ACC_SHIFT];
			res_z_q <= acc_z_q[ACC_SHIFT+DATA_W-1:ACC_SHIFT];
		end
	end

	assign out_valid  = out_valid_q;
	assign sampled_vx = res_x_q;
	assign sampled_vy = res_y_q;
	assign sampled_vz = res_z_q;

endmodule
`default_nettype wire

[hdl/tgs_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgs_checker: port-level checks of the trilinear grid sampler
// Watches the handshakes and the busy behavior of the sequencer.
// ----------------------------------------------------------------------------
module tgs_checker
	import tgs_pkg::*;
(
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_stall,
	input wire                      op,
	input wire                      out_valid,
	input wire                      out_stall,
	input wire signed [DATA_W-1:0]  sampled_vx,
	input wire signed [DATA_W-1:0]  sampled_vy,
	input wire signed [DATA_W-1:0]  sampled_vz
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sampled_vx)
			&& $stable(sampled_vy) && $stable(sampled_vz))
		else $error("stalled result changed");

	// a sample item keeps the block busy on the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_SAMPLE) |=> in_stall)
		else $error("block ready right after a sample item");

	// a write item leaves the block ready on the next cycle and makes no result
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_WRITE) |=> !in_stall && !$rose(out_valid))
		else $error("write item stalled the block or made a result");

	// a new result appears only at the end of a busy period
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a sample in progress");

endmodule

bind trilinear_grid_sampler_top tgs_checker u_tgs_checker (.*);
`default_nettype wire
